[rtl/clbm_pkg.sv]
// ----------------------------------------------------------------------------
// clbm_pkg: shared types and constants for the character LCD bus master
// Phase codes, request codes, register indexes and the power-up command list.
// ----------------------------------------------------------------------------
`default_nettype none

package clbm_pkg;

  localparam int unsigned TimerWidthDefault = 24;
  localparam int unsigned CfgWidth          = 24;
  localparam int unsigned CfgIdxWidth       = 2;
  localparam int unsigned InDataWidth       = 16;
  localparam int unsigned InUserWidth       = 2;
  localparam int unsigned OutDataWidth      = 16;

  localparam logic [23:0] PowerUpWaitReset = 24'd1500000;
  localparam logic [23:0] ShortWaitReset   = 24'd1950;
  localparam logic [23:0] ClearWaitReset   = 24'd100000;
  localparam logic [7:0]  StrobeReset      = 8'd2;

  localparam logic [2:0] InitDone = 3'd4;
  localparam logic [2:0] InitClearStep = 3'd3;

  typedef enum logic [3:0] {
    PH_POWER  = 4'd0,
    PH_WAIT   = 4'd1,
    PH_STROBE = 4'd2,
    PH_GAP    = 4'd3,
    PH_WRITE  = 4'd4,
    PH_IDLE   = 4'd5
  } phase_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DATA  = 2'd1,
    OP_CMD   = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_POWER_UP = 2'd0,
    REG_SHORT    = 2'd1,
    REG_CLEAR    = 2'd2,
    REG_STROBE   = 2'd3
  } reg_idx_e;

  // function set, display on with cursor and blink, clear, entry mode
  function automatic logic [7:0] init_cmd(input logic [1:0] step);
    logic [7:0] cmd;
    case (step)
      2'd0:    cmd = 8'h38;
      2'd1:    cmd = 8'h0F;
      2'd2:    cmd = 8'h01;
      default: cmd = 8'h06;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

[rtl/char_lcd_bus_master_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_bus_master_unit: bus master for an 8-bit character LCD
// Power-up sequence, busy-flag polling and byte writes, one beat per tick.
// ----------------------------------------------------------------------------
// Usage: every input beat is one LCD tick. tuser carries the request
// (tick, data write, command write), tdata the byte and the sampled D7.
// Each input beat yields exactly one output beat with the pin levels for
// that tick (RS, RW, E, data byte, bus drive) and a ready flag; a write
// request is only taken in a tick whose result shows ready, else dropped.
// The pin levels land in the output register on the edge that accepts the
// beat. Throughput is one beat per cycle; the output register refills on the
// same edge it drains, so back-to-back beats flow while the receiver keeps
// tready high. When the receiver stalls, the held result blocks
// s_axis_tready and no state moves until it is taken.
// After reset the power-up wait starts, then 0x38, 0x0F, 0x01 and 0x06 are
// written, each behind busy polling. Wait registers of zero act as one tick;
// the tick timer saturates at its TIMER_WIDTH maximum, ending any wait. Write
// configuration (cfg_we_i/cfg_idx_i/cfg_wdata_i) only while idle; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_bus_master_unit #(
  parameter int unsigned TIMER_WIDTH = clbm_pkg::TimerWidthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [clbm_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [clbm_pkg::CfgWidth-1:0]     cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] byte_value, [8] bus_d7, [15:9] zero
  input  wire logic [clbm_pkg::InDataWidth-1:0]  s_axis_tdata,
  // [1:0] operation
  input  wire logic [clbm_pkg::InUserWidth-1:0]  s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] reg_select, [1] read_write, [2] enable, [10:3] bus_out,
  // [11] bus_drive, [12] ready_res, [15:13] zero
  output logic [clbm_pkg::OutDataWidth-1:0]      m_axis_tdata
);
  import clbm_pkg::*;

  localparam int unsigned CmpWidth = 33;

  logic [23:0]            power_wait_q, short_wait_q, clear_wait_q;
  logic [7:0]             strobe_q;
  phase_e                 phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] tick_timer_q, tick_timer_d;
  logic [2:0]             init_step_q, init_step_d;
  logic [7:0]             pend_byte_q, pend_byte_d;
  logic                   pend_data_q, pend_data_d;
  logic                   m_valid_q;
  logic [OutDataWidth-1:0] m_data_q, m_data_d;

  logic                   s_fire;
  op_e                    op;
  logic [7:0]             in_byte;
  logic                   in_d7;
  logic [23:0]            limit;
  logic [TIMER_WIDTH-1:0] tmr_inc;
  logic                   tmr_done;
  logic                   rs, rw, en, drive, rdy;
  logic [7:0]             bus;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign op      = op_e'(s_axis_tuser[1:0]);
  assign in_byte = s_axis_tdata[7:0];
  assign in_d7   = s_axis_tdata[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_wait_q <= PowerUpWaitReset;
      short_wait_q <= ShortWaitReset;
      clear_wait_q <= ClearWaitReset;
      strobe_q     <= StrobeReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_POWER_UP: power_wait_q <= cfg_wdata_i;
        REG_SHORT:    short_wait_q <= cfg_wdata_i;
        REG_CLEAR:    clear_wait_q <= cfg_wdata_i;
        REG_STROBE:   strobe_q     <= cfg_wdata_i[7:0];
        default:      ;
      endcase
    end
  end

  // wait length for the phase being timed
  always_comb begin
    case (phase_q)
      PH_POWER:  limit = power_wait_q;
      PH_WAIT:   limit = (init_step_q >= InitClearStep) ? clear_wait_q : short_wait_q;
      PH_STROBE: limit = {16'd0, strobe_q};
      default:   limit = '0;
    endcase
  end

  // a limit of zero compares like one, so a wait always spans a tick
  assign tmr_inc  = tick_timer_q + TIMER_WIDTH'(1);
  assign tmr_done = (&tick_timer_q) || (CmpWidth'(tmr_inc) >= CmpWidth'(limit));

  always_comb begin
    phase_d      = phase_q;
    tick_timer_d = tick_timer_q;
    init_step_d  = init_step_q;
    pend_byte_d  = pend_byte_q;
    pend_data_d  = pend_data_q;
    rs = 1'b0; rw = 1'b0; en = 1'b0; bus = 8'd0; drive = 1'b1; rdy = 1'b0;
    case (phase_q)
      PH_POWER: begin
        tick_timer_d = tmr_done ? '0 : tmr_inc;
        if (tmr_done) begin
          init_step_d = '0;
          pend_byte_d = init_cmd(2'd0);
          pend_data_d = 1'b0;
          phase_d     = PH_STROBE;
        end
      end
      PH_WAIT: begin
        rs  = pend_data_q;
        bus = pend_byte_q;
        tick_timer_d = tmr_done ? '0 : tmr_inc;
        if (tmr_done) begin
          pend_byte_d = init_cmd(init_step_q[1:0]);
          pend_data_d = 1'b0;
          phase_d     = PH_STROBE;
        end
      end
      PH_STROBE: begin
        rw = 1'b1; en = 1'b1; drive = 1'b0;
        tick_timer_d = tmr_done ? '0 : tmr_inc;
        if (tmr_done) begin
          // D7 sampled on the last strobe tick
          phase_d = in_d7 ? PH_GAP : PH_WRITE;
        end
      end
      PH_GAP: begin
        rw = 1'b1; drive = 1'b0;
        tick_timer_d = '0;
        phase_d      = PH_STROBE;
      end
      PH_WRITE: begin
        rs  = pend_data_q;
        en  = 1'b1;
        bus = pend_byte_q;
        tick_timer_d = '0;
        if (init_step_q < InitDone) begin
          init_step_d = init_step_q + 3'd1;
          phase_d     = (init_step_d == InitDone) ? PH_IDLE : PH_WAIT;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        rs  = pend_data_q;
        bus = pend_byte_q;
        rdy = 1'b1;
        phase_d = PH_IDLE;
        if (op == OP_DATA || op == OP_CMD) begin
          pend_byte_d  = in_byte;
          pend_data_d  = (op == OP_DATA);
          tick_timer_d = '0;
          phase_d      = PH_STROBE;
        end
      end
    endcase
    m_data_d = {3'd0, rdy, drive, bus, en, rw, rs};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_POWER;
      tick_timer_q <= '0;
      init_step_q  <= '0;
      pend_byte_q  <= '0;
      pend_data_q  <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (s_fire) begin
        phase_q      <= phase_d;
        tick_timer_q <= tick_timer_d;
        init_step_q  <= init_step_d;
        pend_byte_q  <= pend_byte_d;
        pend_data_q  <= pend_data_d;
        m_valid_q    <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      m_data_q <= m_data_d;
    end
  end

`ifndef SYNTHESIS
  a_init_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_step_q <= InitDone)
    else $error("init step past done");

  a_gap_to_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && phase_q == PH_GAP |=> phase_q == PH_STROBE && tick_timer_q == '0)
    else $error("gap did not restart strobe");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && phase_q == PH_IDLE |=> m_valid_q && m_data_q[12])
    else $error("idle tick without ready flag");

  a_strobe_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && phase_q == PH_STROBE |=> m_data_q[2] && m_data_q[1] && !m_data_q[11])
    else $error("strobe beat drives bus");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_valid_q |-> s_axis_tready)
    else $error("empty output register blocks input");
`endif

endmodule

`default_nettype wire
